// File: src/pfs_pkg.sv
// pfs_pkg: shared constants, codes and control structs of the page frame free stack
// used by pfs_ctrl, pfs_dp and page_frame_free_stack_top; depends on nothing
`default_nettype none

package pfs_pkg;

  // default sizes
  localparam int unsigned STORE_DEPTH_DEF = 1024;
  localparam int unsigned PAGE_BYTES_DEF  = 4096;

  // field widths
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PCOUNT_W = 21;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PADDR_W  = 3;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // register index (word address bit of paddr)
  localparam logic REG_KSTART = 1'b0;
  localparam logic REG_KEND   = 1'b1;

  // register reset values
  localparam logic [ADDR_W-1:0] KSTART_RST = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] KEND_RST   = 32'h0040_0000;

  // controller states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ALLOC = 4'b0010,
    S_FREE  = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture a new item
    logic pop;    // allocate: pop one entry or flag empty
    logic step;   // free: handle one page of the walk
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;  // no pages left in the walk
  } stat_t;

endpackage

`default_nettype wire

// File: src/pfs_ctrl.sv
// pfs_ctrl: controller state machine of the page frame free stack
// depends on pfs_pkg (state enum, command and status structs)
`default_nettype none

module pfs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          opcode_i,
  input  pfs_pkg::stat_t     stat_i,
  output pfs_pkg::cmd_t      cmd_o,
  output logic               busy_o,
  output logic               done_o
);

  pfs_pkg::state_e state_q, state_d;
  logic            accept;

  // a new item may enter from idle or while the last result is shown
  assign busy_o = !(state_q == pfs_pkg::S_IDLE || state_q == pfs_pkg::S_RESP);
  assign done_o = (state_q == pfs_pkg::S_RESP);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.load = accept;
    case (state_q)
      pfs_pkg::S_IDLE, pfs_pkg::S_RESP: begin
        if (accept) begin
          state_d = (opcode_i == pfs_pkg::OP_FREE) ? pfs_pkg::S_FREE : pfs_pkg::S_ALLOC;
        end else begin
          state_d = pfs_pkg::S_IDLE;
        end
      end
      pfs_pkg::S_ALLOC: begin
        cmd_o.pop = 1'b1;
        state_d   = pfs_pkg::S_RESP;
      end
      pfs_pkg::S_FREE: begin
        if (stat_i.walk_done) begin
          state_d = pfs_pkg::S_RESP;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        state_d = pfs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// File: src/pfs_dp.sv
// pfs_dp: datapath of the page frame free stack: address store, fill count, walk registers
// depends on pfs_pkg (widths, status codes, command and status structs)
`default_nettype none

module pfs_dp #(
  parameter int unsigned STORE_DEPTH = pfs_pkg::STORE_DEPTH_DEF,
  parameter int unsigned PAGE_BYTES  = pfs_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  pfs_pkg::cmd_t                        cmd_i,
  output pfs_pkg::stat_t                       stat_o,
  input  wire logic [pfs_pkg::ADDR_W-1:0]      start_address_i,
  input  wire logic [pfs_pkg::PCOUNT_W-1:0]    page_count_i,
  input  wire logic [pfs_pkg::ADDR_W-1:0]      kernel_start_i,
  input  wire logic [pfs_pkg::ADDR_W-1:0]      kernel_end_i,
  output logic      [pfs_pkg::ADDR_W-1:0]      page_address_o,
  output logic      [pfs_pkg::STATUS_W-1:0]    status_o
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  logic [pfs_pkg::ADDR_W-1:0]   mem_q [STORE_DEPTH];
  logic [pfs_pkg::ADDR_W-1:0]   rdata_q;
  logic [CW-1:0]                count_q;
  logic [pfs_pkg::ADDR_W-1:0]   addr_q;
  logic [pfs_pkg::PCOUNT_W-1:0] remain_q;
  logic [pfs_pkg::STATUS_W-1:0] status_q;
  logic                         from_mem_q;

  logic          empty, full, reserved, do_push, do_pop;
  logic [CW-1:0] count_dec;

  assign empty     = (count_q == '0);
  assign full      = !(count_q < CW'(STORE_DEPTH));
  assign count_dec = count_q - CW'(1);
  assign reserved  = (addr_q == '0) ||
                     ((addr_q >= kernel_start_i) && (addr_q < kernel_end_i));
  assign do_push   = cmd_i.step && !reserved && !full;
  assign do_pop    = cmd_i.pop && !empty;

  assign stat_o.walk_done = (remain_q == '0);
  assign page_address_o   = from_mem_q ? rdata_q : '0;
  assign status_o         = status_q;

  // store: one write port for pushes, one registered read port for pops
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[count_q[AW-1:0]] <= addr_q;
    end
    if (do_pop) begin
      rdata_q <= mem_q[count_dec[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (do_push) begin
      count_q <= count_q + CW'(1);
    end else if (do_pop) begin
      count_q <= count_dec;
    end
  end

  // walk and result registers, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q     <= start_address_i;
      remain_q   <= page_count_i;
      status_q   <= pfs_pkg::ST_OK;
      from_mem_q <= 1'b0;
    end else if (cmd_i.pop) begin
      from_mem_q <= !empty;
      status_q   <= empty ? pfs_pkg::ST_EMPTY : pfs_pkg::ST_OK;
    end else if (cmd_i.step) begin
      addr_q   <= addr_q + pfs_pkg::ADDR_W'(PAGE_BYTES);
      remain_q <= remain_q - pfs_pkg::PCOUNT_W'(1);
      if (!reserved && full) begin
        status_q <= pfs_pkg::ST_FULL;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/page_frame_free_stack_top.sv
// page_frame_free_stack_top: free page frame stack with APB-style register port
// depends on pfs_pkg, pfs_ctrl and pfs_dp
//
//  channel   | signals                                            | transfer when
//  ----------+----------------------------------------------------+---------------------------
//  command   | start, busy, opcode_i, start_address_i, page_count_i | start high and busy low
//  result    | done_o, page_address_o, status_o                   | every cycle done_o is high
//  register  | psel, penable, pwrite, paddr, pwdata, prdata, pready | psel, penable, pwrite high
//
// allocate: pops the store through its registered read port, then shows the result
// free: one page a cycle on the single store write port, then a check that the walk is done
// and the result; a new command is taken in the result cycle
// done_o is high for exactly one cycle per item; the receiver cannot stall
// reset clears the fill count and state machine and presets the kernel range registers; store
// contents are kept, entries at or above the count are never read, so no clearing pass
`default_nettype none

module page_frame_free_stack_top #(
  parameter int unsigned STORE_DEPTH = pfs_pkg::STORE_DEPTH_DEF,
  parameter int unsigned PAGE_BYTES  = pfs_pkg::PAGE_BYTES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          opcode_i,
  input  wire logic [pfs_pkg::ADDR_W-1:0]    start_address_i,
  input  wire logic [pfs_pkg::PCOUNT_W-1:0]  page_count_i,
  // result channel
  output logic                               done_o,
  output logic      [pfs_pkg::ADDR_W-1:0]    page_address_o,
  output logic      [pfs_pkg::STATUS_W-1:0]  status_o,
  // register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pfs_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);

  pfs_pkg::cmd_t  cmd;
  pfs_pkg::stat_t stat;

  logic [pfs_pkg::ADDR_W-1:0] kstart_q, kend_q;
  logic                       reg_wr;

  // register file: word index sits in paddr bit 2
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kstart_q <= pfs_pkg::KSTART_RST;
      kend_q   <= pfs_pkg::KEND_RST;
    end else if (reg_wr) begin
      if (paddr[2] == pfs_pkg::REG_KSTART) begin
        kstart_q <= pwdata;
      end else begin
        kend_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == pfs_pkg::REG_KEND) ? kend_q : kstart_q;

  // sequencing
  pfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // store, fill count and page walk
  pfs_dp #(
    .STORE_DEPTH (STORE_DEPTH),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .start_address_i (start_address_i),
    .page_count_i    (page_count_i),
    .kernel_start_i  (kstart_q),
    .kernel_end_i    (kend_q),
    .page_address_o  (page_address_o),
    .status_o        (status_o)
  );

`ifndef SYNTHESIS
  // a taken command always makes the block busy in the following cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("command taken but block not busy");

  // one result per item: never two strobes in a row
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");

  // an empty allocate returns address zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == pfs_pkg::ST_EMPTY) |-> (page_address_o == '0))
    else $error("empty status with nonzero address");

  // status carries only defined codes
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == pfs_pkg::ST_OK || status_o == pfs_pkg::ST_EMPTY ||
                status_o == pfs_pkg::ST_FULL))
    else $error("undefined status code");
`endif

endmodule

`default_nettype wire

// File: test/tb_page_frame_free_stack_top.sv
// tb_page_frame_free_stack_top: self-checking bench for the page frame free stack
// drives allocate and free commands and the kernel range registers, checks every result
// against an in-bench model of the stack; depends on pfs_pkg and page_frame_free_stack_top

module tb_page_frame_free_stack_top;

  // expected result of one command
  typedef struct packed {
    logic [pfs_pkg::ADDR_W-1:0]   page_addr;
    logic [pfs_pkg::STATUS_W-1:0] status;
  } frame_result_t;

  // traffic mixes: drain pops most of the time, even keeps the stack level,
  // fill pushes long page runs until the stack overflows
  typedef enum int unsigned {
    MIX_DRAIN,
    MIX_EVEN,
    MIX_FILL
  } traffic_mix_e;

  // clock, reset and all block inputs start at known values
  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         start           = 1'b0;
  logic                         opcode_i        = pfs_pkg::OP_ALLOC;
  logic [pfs_pkg::ADDR_W-1:0]   start_address_i = '0;
  logic [pfs_pkg::PCOUNT_W-1:0] page_count_i    = '0;
  logic                         psel            = 1'b0;
  logic                         penable         = 1'b0;
  logic                         pwrite          = 1'b0;
  logic [pfs_pkg::PADDR_W-1:0]  paddr           = '0;
  logic [31:0]                  pwdata          = '0;

  logic                         busy;
  logic                         done_o;
  logic [pfs_pkg::ADDR_W-1:0]   page_address_o;
  logic [pfs_pkg::STATUS_W-1:0] status_o;
  logic [31:0]                  prdata;
  logic                         pready;

  // model of the stack: contents, fill level and the kernel range it excludes
  logic [pfs_pkg::ADDR_W-1:0] shadow_stack [pfs_pkg::STORE_DEPTH_DEF];
  int unsigned                shadow_fill   = 0;
  logic [pfs_pkg::ADDR_W-1:0] shadow_kstart = pfs_pkg::KSTART_RST;
  logic [pfs_pkg::ADDR_W-1:0] shadow_kend   = pfs_pkg::KEND_RST;

  // results still owed by the block, oldest first
  frame_result_t frame_results_q [$];

  bit          gaps_enabled = 1'b1;
  int unsigned errors       = 0;
  int unsigned n_alloc      = 0;
  int unsigned n_free       = 0;
  int unsigned n_checked    = 0;
  int unsigned n_empty_seen = 0;
  int unsigned n_full_seen  = 0;
  int unsigned pages_pushed = 0;

  page_frame_free_stack_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .start_address_i(start_address_i),
    .page_count_i   (page_count_i),
    .done_o         (done_o),
    .page_address_o (page_address_o),
    .status_o       (status_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 10 time unit clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // applies one command to the model and returns the result the block owes for it;
  // a free walks the pages one by one so that wrap, the zero page and the kernel
  // range are judged per page, and overflow only flags the pages that are lost
  function automatic frame_result_t predict_frame_op(
      input logic op,
      input logic [pfs_pkg::ADDR_W-1:0] base,
      input logic [pfs_pkg::PCOUNT_W-1:0] pages);
    frame_result_t              r;
    logic [pfs_pkg::ADDR_W-1:0] a;
    r.page_addr = '0;
    r.status    = pfs_pkg::ST_OK;
    a           = base;
    if (op == pfs_pkg::OP_ALLOC) begin
      if (shadow_fill == 0) begin
        r.status = pfs_pkg::ST_EMPTY;
      end else begin
        shadow_fill--;
        r.page_addr = shadow_stack[shadow_fill];
      end
    end else begin
      for (int unsigned i = 0; i < pages; i++) begin
        // zero page and the kernel image range never go on the stack
        if (a != '0 && !(a >= shadow_kstart && a < shadow_kend)) begin
          if (shadow_fill < pfs_pkg::STORE_DEPTH_DEF) begin
            shadow_stack[shadow_fill] = a;
            shadow_fill++;
            pages_pushed++;
          end else begin
            r.status = pfs_pkg::ST_FULL;
          end
        end
        a = a + pfs_pkg::PAGE_BYTES_DEF;
      end
    end
    return r;
  endfunction

  // sends one command; optionally idles first, then holds start high
  // until the transfer happens and records what the block should answer
  task automatic send_item(input logic op, input logic [pfs_pkg::ADDR_W-1:0] addr,
                           input logic [pfs_pkg::PCOUNT_W-1:0] pages);
    int unsigned idle_len;
    @(negedge clk_i);
    if (gaps_enabled && $urandom_range(0, 2) == 0) begin
      idle_len = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (idle_len) @(negedge clk_i);
    end
    start           <= 1'b1;
    opcode_i        <= op;
    start_address_i <= addr;
    page_count_i    <= pages;
    // transfer at the first rising edge that sees busy low
    do @(posedge clk_i); while (busy);
    frame_results_q.push_back(predict_frame_op(op, addr, pages));
    if (op == pfs_pkg::OP_ALLOC) n_alloc++;
    else n_free++;
  endtask

  // drops start and waits until every owed result has come back, plus a short pause
  // so the block is surely back in idle
  task automatic wait_results_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (frame_results_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // register port: setup cycle, then access cycle until pready
  task automatic reg_access(input logic is_write, input logic idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // reads both range registers back and compares them with the model
  task automatic check_kernel_regs();
    logic [31:0] got;
    reg_access(1'b0, pfs_pkg::REG_KSTART, '0, got);
    if (got !== shadow_kstart) begin
      errors++;
      $display("%0t: kernel_start readback expected %h got %h", $time, shadow_kstart, got);
    end
    reg_access(1'b0, pfs_pkg::REG_KEND, '0, got);
    if (got !== shadow_kend) begin
      errors++;
      $display("%0t: kernel_end readback expected %h got %h", $time, shadow_kend, got);
    end
  endtask

  // new kernel range, written only once the block has gone quiet
  task automatic set_kernel_range(input logic [pfs_pkg::ADDR_W-1:0] ks,
                                  input logic [pfs_pkg::ADDR_W-1:0] ke);
    logic [31:0] unused;
    wait_results_drained();
    reg_access(1'b1, pfs_pkg::REG_KSTART, ks, unused);
    shadow_kstart = ks;
    reg_access(1'b1, pfs_pkg::REG_KEND, ke, unused);
    shadow_kend = ke;
    check_kernel_regs();
  endtask

  // one stretch of random commands under a random kernel range
  task automatic run_traffic_phase(input int unsigned n_items, input traffic_mix_e mix,
                                   input bit with_gaps);
    int unsigned                  alloc_pct;
    int unsigned                  pick;
    logic                         op;
    logic [pfs_pkg::ADDR_W-1:0]   addr;
    logic [pfs_pkg::PCOUNT_W-1:0] pages;
    logic [pfs_pkg::ADDR_W-1:0]   ks;
    logic [pfs_pkg::ADDR_W-1:0]   ke;
    // range: fully random (often inverted), narrow, the reset one, or a small inverted one
    pick = $urandom_range(0, 3);
    case (pick)
      0: begin
        ks = $urandom;
        ke = $urandom;
      end
      1: begin
        ks = $urandom & 32'hFFF0_0000;
        ke = ks + ($urandom_range(1, 64) << 12);
      end
      2: begin
        ks = pfs_pkg::KSTART_RST;
        ke = pfs_pkg::KEND_RST;
      end
      default: begin
        ke = $urandom & 32'hFFFF_F000;
        ks = ke + ($urandom_range(0, 16) << 12);
      end
    endcase
    set_kernel_range(ks, ke);
    gaps_enabled = with_gaps;
    case (mix)
      MIX_DRAIN: alloc_pct = 98;
      MIX_EVEN:  alloc_pct = 50;
      default:   alloc_pct = 20;
    endcase
    for (int unsigned k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < alloc_pct) begin
        // address and count are don't-care on allocate; toggle them anyway
        op    = pfs_pkg::OP_ALLOC;
        addr  = $urandom;
        pages = pfs_pkg::PCOUNT_W'($urandom_range(0, 21'h1F_FFFF));
      end else begin
        op   = pfs_pkg::OP_FREE;
        pick = $urandom_range(0, 99);
        if (mix != MIX_FILL) pages = pfs_pkg::PCOUNT_W'($urandom_range(0, 3));
        else if (pick < 70) pages = pfs_pkg::PCOUNT_W'($urandom_range(0, 8));
        else if (pick < 95) pages = pfs_pkg::PCOUNT_W'($urandom_range(9, 64));
        else pages = pfs_pkg::PCOUNT_W'($urandom_range(256, 1100));
        // start pages: plain aligned, straddling either end of the kernel range,
        // running through the top of the address space, or unaligned
        pick = $urandom_range(0, 9);
        if (pick < 4) addr = $urandom & 32'hFFFF_F000;
        else if (pick < 6) addr = shadow_kstart - ($urandom_range(0, 8) << 12);
        else if (pick < 8) addr = shadow_kend - ($urandom_range(0, 8) << 12);
        else if (pick < 9) addr = 32'hFFFF_F000 - ($urandom_range(0, 8) << 12);
        else addr = $urandom;
      end
      send_item(op, addr, pages);
    end
  endtask

  // register values straight out of reset
  task automatic test_register_reset();
    check_kernel_regs();
  endtask

  // hand-picked commands under the reset kernel range [1 MiB, 4 MiB)
  task automatic test_directed_cases();
    gaps_enabled = 1'b1;
    send_item(pfs_pkg::OP_ALLOC, '0, '0);                     // pop from an empty stack
    send_item(pfs_pkg::OP_FREE, '0, '0);                      // free of zero pages
    send_item(pfs_pkg::OP_FREE, '0, 21'd1);                   // zero page is never pushed
    send_item(pfs_pkg::OP_ALLOC, '0, '0);                     // still empty
    send_item(pfs_pkg::OP_FREE, 32'h000F_E000, 21'd4);        // runs into the kernel range
    send_item(pfs_pkg::OP_FREE, 32'h003F_F000, 21'd2);        // leaves the kernel range
    send_item(pfs_pkg::OP_FREE, 32'hFFFF_F000, 21'd3);        // wraps through page zero
    send_item(pfs_pkg::OP_FREE, 32'h1234_5677, 21'd1);        // unaligned start
    send_item(pfs_pkg::OP_FREE, 32'hFFFF_FFFF, 21'd2);        // top address, wraps unaligned
    send_item(pfs_pkg::OP_ALLOC, '0, '0);                     // last in, first out
    send_item(pfs_pkg::OP_ALLOC, '0, '0);
    send_item(pfs_pkg::OP_ALLOC, '0, '0);
    send_item(pfs_pkg::OP_FREE, 32'h4000_0000, 21'd1100);     // overflows the stack
    send_item(pfs_pkg::OP_FREE, 32'h8000_0000, 21'd1);        // push onto a full stack
    send_item(pfs_pkg::OP_ALLOC, '0, '0);
    send_item(pfs_pkg::OP_FREE, 32'h9000_0000, 21'h1F_FFFF);  // count at the field maximum
    send_item(pfs_pkg::OP_FREE, '0, 21'd1048576);             // count of 2^20 pages
    send_item(pfs_pkg::OP_ALLOC, '0, '0);
    send_item(pfs_pkg::OP_ALLOC, '0, '0);
    send_item(pfs_pkg::OP_ALLOC, 32'hFFFF_FFFF, 21'h1F_FFFF); // allocate ignores its fields
  endtask

  // each kernel range setting: make room, free a few pages across the range edge,
  // then pop them back to see which ones were kept
  task automatic test_kernel_ranges();
    logic [pfs_pkg::ADDR_W-1:0] ks_tab   [7] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                 32'h0000_0000, 32'h8000_0000,
                                                 32'h1000_0000, 32'h1000_0000,
                                                 pfs_pkg::KSTART_RST};
    logic [pfs_pkg::ADDR_W-1:0] ke_tab   [7] = '{32'h0000_0000, 32'h0000_0000,
                                                 32'hFFFF_FFFF, 32'h8000_0000,
                                                 32'h1001_0000, 32'h1001_0000,
                                                 pfs_pkg::KEND_RST};
    logic [pfs_pkg::ADDR_W-1:0] base_tab [7] = '{32'hFFFF_F000, 32'hFFFF_F000,
                                                 32'hFFFF_DFFF, 32'h7FFF_E000,
                                                 32'h0FFF_E000, 32'h1000_E000,
                                                 32'h000F_E000};
    for (int i = 0; i < 7; i++) begin
      set_kernel_range(ks_tab[i], ke_tab[i]);
      repeat (4) send_item(pfs_pkg::OP_ALLOC, '0, '0);
      send_item(pfs_pkg::OP_FREE, base_tab[i], 21'd4);
      repeat (4) send_item(pfs_pkg::OP_ALLOC, '0, '0);
    end
  endtask

  // long random run: drain the stack down to empty, churn around empty, then overflow it
  task automatic test_random_traffic();
    repeat (5) run_traffic_phase(210, MIX_DRAIN, $urandom_range(0, 3) != 0);
    run_traffic_phase(120, MIX_EVEN, 1'b1);
    run_traffic_phase(120, MIX_FILL, 1'b1);
  endtask

  // back-to-back commands with no idle cycles at all
  task automatic test_steady_tail();
    run_traffic_phase(120, MIX_EVEN, 1'b0);
  endtask

  // result checker: every done_o strobe is a transfer, matched against the oldest
  // expectation field by field
  always @(posedge clk_i) begin
    frame_result_t want;
    if (rst_ni && done_o) begin
      if (frame_results_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, nothing owed: page_address %h status %0d",
                 $time, page_address_o, status_o);
      end else begin
        want = frame_results_q.pop_front();
        n_checked++;
        if (want.status == pfs_pkg::ST_EMPTY) n_empty_seen++;
        if (want.status == pfs_pkg::ST_FULL) n_full_seen++;
        if (page_address_o !== want.page_addr) begin
          errors++;
          $display("%0t: page_address expected %h got %h", $time, want.page_addr,
                   page_address_o);
        end
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, want.status, status_o);
        end
      end
    end
  end

  // test sequence
  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_register_reset();
    test_directed_cases();
    test_kernel_ranges();
    test_random_traffic();
    test_steady_tail();
    // let any stray strobe show up before judging
    wait_results_drained();
    repeat (20) @(negedge clk_i);
    $display("coverage: %0d allocates and %0d frees sent, %0d results checked",
             n_alloc, n_free, n_checked);
    $display("coverage: %0d empty pops, %0d overflowing frees, %0d pages pushed",
             n_empty_seen, n_full_seen, pages_pushed);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog: stops a hung run and reports how many results are still owed
  initial begin
    #200_000_000;
    $display("timeout with %0d results still owed", frame_results_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
src/pfs_pkg.sv
src/pfs_ctrl.sv
src/pfs_dp.sv
src/page_frame_free_stack_top.sv
test/tb_page_frame_free_stack_top.sv
